// ===== rtl/line_raster_generator_top_macros.svh =====
// assertion macros shared by the line raster checker
`ifndef LINE_RASTER_GENERATOR_TOP_MACROS_SVH
`define LINE_RASTER_GENERATOR_TOP_MACROS_SVH

// implication checked on the same edge
`define LRG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the next edge
`define LRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrg_pkg.sv =====
// types and constants of the line raster generator
`timescale 1ns / 1ps

package lrg_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 32;
    localparam int ERR_BITS   = COORD_BITS + 1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef struct packed {
        logic   opcode;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t pixel_value;
    } in_word_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        color_t out_color;
        logic   last_pixel;
    } out_word_t;

    typedef struct packed {
        logic   busy;
        coord_t cur_x;
        coord_t cur_y;
        err_t   error_acc;
        coord_t steps_left;
        coord_t major_delta;
        coord_t minor_delta;
        logic   x_major;
        logic   x_move;
        logic   x_neg;
        logic   y_move;
        logic   y_neg;
        color_t line_color;
    } line_state_t;

endpackage

// ===== rtl/lrg_step.sv =====
// one bresenham step: line setup on start, next pixel on tick while a line is in progress
`timescale 1ns / 1ps

module lrg_step
    import lrg_pkg::*;
(
    input  in_word_t    word,
    input  line_state_t state,
    output line_state_t state_next,
    output out_word_t   pixel,
    output logic        emit
);

    function automatic coord_t step_coord(coord_t c, logic mv, logic neg);
        coord_t r;
        r = c;
        if (mv)
        begin
            r = neg ? c - coord_t'(1) : c + coord_t'(1);
        end
        return r;
    endfunction

    logic   x_gt, x_lt, y_gt, y_lt;
    coord_t adx, ady;
    logic   major_is_x;
    coord_t major_d, minor_d;
    err_t   err_diff;
    coord_t steps_dec;

    assign x_gt = word.end_x > word.start_x;
    assign x_lt = word.end_x < word.start_x;
    assign y_gt = word.end_y > word.start_y;
    assign y_lt = word.end_y < word.start_y;
    assign adx  = x_gt ? word.end_x - word.start_x : word.start_x - word.end_x;
    assign ady  = y_gt ? word.end_y - word.start_y : word.start_y - word.end_y;
    assign major_is_x = adx > ady;
    assign major_d    = major_is_x ? adx : ady;
    assign minor_d    = major_is_x ? ady : adx;

    assign err_diff  = state.error_acc - $signed({1'b0, state.minor_delta});
    assign steps_dec = state.steps_left - coord_t'(1);

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        if (word.opcode == OP_START)
        begin
            state_next.x_move      = x_gt | x_lt;
            state_next.x_neg       = x_lt;
            state_next.y_move      = y_gt | y_lt;
            state_next.y_neg       = y_lt;
            state_next.x_major     = major_is_x;
            state_next.major_delta = major_d;
            state_next.minor_delta = minor_d;
            state_next.error_acc   = $signed({1'b0, major_d >> 1});
            state_next.steps_left  = major_d;
            state_next.cur_x       = word.start_x;
            state_next.cur_y       = word.start_y;
            state_next.line_color  = word.pixel_value;
            state_next.busy        = major_d != '0;
            emit                   = 1'b1;
        end
        else if (state.busy)
        begin
            // negative error means a diagonal step
            if (err_diff < 0)
            begin
                state_next.error_acc = err_diff + $signed({1'b0, state.major_delta});
                state_next.cur_x = step_coord(state.cur_x, state.x_move, state.x_neg);
                state_next.cur_y = step_coord(state.cur_y, state.y_move, state.y_neg);
            end
            else
            begin
                state_next.error_acc = err_diff;
                if (state.x_major)
                begin
                    state_next.cur_x = step_coord(state.cur_x, state.x_move, state.x_neg);
                end
                else
                begin
                    state_next.cur_y = step_coord(state.cur_y, state.y_move, state.y_neg);
                end
            end
            state_next.steps_left = steps_dec;
            state_next.busy       = steps_dec != '0;
            emit                  = 1'b1;
        end
    end

    assign pixel.out_x      = state_next.cur_x;
    assign pixel.out_y      = state_next.cur_y;
    assign pixel.out_color  = state_next.line_color;
    assign pixel.last_pixel = ~state_next.busy;

endmodule

// ===== rtl/line_raster_generator_top.sv =====
// top level of the bresenham line raster generator
`timescale 1ns / 1ps
// Input channel (in_valid/in_ready/in_data) takes one word per cycle unless
// stalled. A word with opcode start latches both endpoints and the color
// and yields the first pixel; a word with opcode tick yields the next pixel
// of the current line, or nothing when no line is in progress. A start
// during a line drops that line. Output channel (out_valid/out_ready/out_data)
// carries one pixel word; the last pixel of each line has last_pixel set.
// Output: the pixel for an accepted word is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle unless stalled, set by the combinational
// step logic that feeds both the line state and the output register; a line
// of major delta N takes N+1 words (one start and N ticks).
// Stall: while the output register holds a pixel that is not taken, in_ready
// is low; in_ready stays high in a cycle in which the held pixel is taken.
// Reset: rst_n clears the line state and the output valid flag; the block is
// idle and ready in the first cycle after reset.

module line_raster_generator_top
    import lrg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    line_state_t state_reg, state_next;
    out_word_t   out_data_reg, pixel;
    logic        out_valid_reg;
    logic        emit, accept;

    lrg_step u_step (
        .word       (in_data),
        .state      (state_reg),
        .state_next (state_next),
        .pixel      (pixel),
        .emit       (emit)
    );

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= pixel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/lrg_checker.sv =====
// port-level checks of the line raster generator and their bind
`timescale 1ns / 1ps
`include "line_raster_generator_top_macros.svh"

module lrg_checker
    import lrg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    logic stall;
    logic start_take;

    assign stall      = out_valid && !out_ready;
    assign start_take = in_valid && in_ready && in_data.opcode == OP_START;

    `LRG_ASSERT_NEXT(a_out_hold, stall, out_valid, "pixel word dropped")
    `LRG_ASSERT_NEXT(a_out_stable, stall, $stable(out_data), "pixel word changed")
    `LRG_ASSERT_NEXT(a_start_emits, start_take, out_valid, "start gave no pixel")
    `LRG_ASSERT_SAME(a_stall_blocks, stall, !in_ready, "input taken while stalled")
    `LRG_ASSERT_SAME(a_free_ready, !stall, in_ready, "input refused with room")

endmodule

bind line_raster_generator_top lrg_checker u_lrg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
